@@ src/assert_macros.svh @@
// Assertion helper macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds at every clock edge out of reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that an implication holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/csd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package csd_pkg;

    localparam int MaxRows = 1024;
    localparam int MaxCols = 16;
    localparam int MaxNz = 4096;
    localparam int RowW = 11;
    localparam int ColW = 4;
    localparam int PtrW = 13;
    localparam int SlotW = 12;
    localparam int NzColW = 10;
    localparam int DenseAw = 14;
    localparam int PtrAw = 11;
    localparam int QDepth = 4;
    localparam int QAw = 2;

    typedef enum logic [1:0] {
        MODE_DENSE = 2'd0,
        MODE_PTR   = 2'd1,
        MODE_NZ    = 2'd2,
        MODE_ROW   = 2'd3
    } mode_t;

    // Classified request handed from the front part to the back part.
    typedef struct packed {
        mode_t              mode;
        logic [RowW-1:0]    row;
        logic [ColW-1:0]    column;
        logic [PtrW-1:0]    pointer;
        logic [SlotW-1:0]   slot;
        logic [NzColW-1:0]  nz_column;
        logic signed [31:0] value;
    } req_t;

    // Result of one column.
    typedef struct packed {
        logic [9:0]         out_row;
        logic [ColW-1:0]    out_column;
        logic signed [31:0] sum;
        logic               saturated;
        logic               last;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PTR0,
        ST_PTR1,
        ST_NZRD,
        ST_NZWAIT,
        ST_DRD,
        ST_DWAIT,
        ST_MUL,
        ST_ACC,
        ST_EMIT
    } state_t;

    localparam logic [1:0] RegDenseColumns = 2'd0;

endpackage
`default_nettype wire

@@ src/csd_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module csd_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]              rdata
);

    logic [Width-1:0] mem [Depth];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ src/csd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module csd_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire csd_pkg::req_t  in_req,
    output logic                q_valid,
    input  wire logic           q_pop,
    output csd_pkg::req_t       q_req
);
    import csd_pkg::*;

    req_t           buf_reg [QDepth];
    logic [QAw-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [QAw:0]   cnt_reg, cnt_next;
    logic           push;
    logic           keep;

    // Out-of-range requests are dropped here; the back part sees only real work.
    always_comb
    begin
        unique case (in_req.mode)
            MODE_DENSE: keep = (in_req.row < RowW'(MaxRows));
            MODE_PTR:   keep = (in_req.row <= RowW'(MaxRows));
            MODE_NZ:    keep = 1'b1;
            MODE_ROW:   keep = (in_req.row < RowW'(MaxRows));
            default:    keep = 1'b0;
        endcase
    end

    assign in_ready = (cnt_reg != (QAw+1)'(QDepth));
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (cnt_reg != '0);
    assign q_req    = buf_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = q_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (QAw+1)'(push) - (QAw+1)'(q_pop);
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= in_req;
        end
    end

endmodule
`default_nettype wire

@@ src/csd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module csd_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [4:0]     ncols_cfg,
    input  wire logic           q_valid,
    output logic                q_pop,
    input  wire csd_pkg::req_t  q_req,
    output logic                res_valid,
    input  wire logic           res_ready,
    output csd_pkg::res_t       res,
    output logic                busy
);
    import csd_pkg::*;

    state_t state_reg, state_next;

    logic [ColW-1:0]    ncm1;
    logic [ColW-1:0]    col_reg, col_next;
    logic [PtrW-1:0]    k_reg, k_next, end_reg, end_next;
    logic [9:0]         row_reg, row_next;
    logic [NzColW-1:0]  drow_reg, drow_next;
    logic signed [31:0] nzv_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg [MaxCols];
    logic [PtrW-1:0]    ptr_rd;
    logic [31:0]        dense_rd, nzval_rd;
    logic [NzColW-1:0]  nzcol_rd;
    logic [PtrAw-1:0]   ptr_ra;
    logic [DenseAw-1:0] dense_ra;
    logic               dense_we, ptr_we, nz_we;
    logic               res_full_reg;
    logic               is_last;
    logic signed [63:0] sat_sum;
    logic signed [47:0] q;
    logic               ovf;

    // Clamp the column count to 1..MaxCols.
    always_comb
    begin
        priority if (ncols_cfg == 5'd0)
            ncm1 = '0;
        else if (ncols_cfg > 5'(MaxCols))
            ncm1 = ColW'(MaxCols - 1);
        else
            ncm1 = ColW'(ncols_cfg - 5'd1);
    end

    // Stores.
    assign dense_we = q_pop && (q_req.mode == MODE_DENSE);
    assign ptr_we   = q_pop && (q_req.mode == MODE_PTR);
    assign nz_we    = q_pop && (q_req.mode == MODE_NZ);

    always_comb
    begin
        ptr_ra   = (state_reg == ST_IDLE) ? q_req.row : PtrAw'({1'b0, row_reg} + 11'd1);
        dense_ra = {drow_reg, col_reg};
    end

    csd_ram #(.Width(32), .Depth(MaxRows * MaxCols)) u_dense (
        .clk(clk), .we(dense_we), .waddr({q_req.row[9:0], q_req.column}),
        .wdata(q_req.value), .raddr(dense_ra), .rdata(dense_rd));

    csd_ram #(.Width(PtrW), .Depth(2048)) u_ptr (
        .clk(clk), .we(ptr_we), .waddr(q_req.row), .wdata(q_req.pointer),
        .raddr(ptr_ra), .rdata(ptr_rd));

    csd_ram #(.Width(NzColW), .Depth(MaxNz)) u_nzcol (
        .clk(clk), .we(nz_we), .waddr(q_req.slot), .wdata(q_req.nz_column),
        .raddr(k_reg[SlotW-1:0]), .rdata(nzcol_rd));

    csd_ram #(.Width(32), .Depth(MaxNz)) u_nzval (
        .clk(clk), .we(nz_we), .waddr(q_req.slot), .wdata(q_req.value),
        .raddr(k_reg[SlotW-1:0]), .rdata(nzval_rd));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (q_valid && q_req.mode == MODE_ROW) state_next = ST_PTR0;
            ST_PTR0:   state_next = ST_PTR1;
            ST_PTR1:   state_next = ST_NZRD;
            ST_NZRD:
                state_next = (k_reg < end_reg) ? ST_NZWAIT : ST_EMIT;
            ST_NZWAIT:
                state_next = (nzcol_rd < NzColW'(MaxRows - 1) || nzcol_rd == NzColW'(MaxRows - 1))
                             ? ST_DRD : ST_NZRD;
            ST_DRD:    state_next = ST_DWAIT;
            ST_DWAIT:  state_next = ST_MUL;
            ST_MUL:    state_next = ST_ACC;
            ST_ACC:    state_next = (col_reg == ncm1) ? ST_NZRD : ST_DRD;
            ST_EMIT:
                if (!res_full_reg && col_reg == ncm1) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath control and register updates.
    always_comb
    begin
        q_pop     = (state_reg == ST_IDLE) && q_valid;
        col_next  = col_reg;
        k_next    = k_reg;
        end_next  = end_reg;
        row_next  = row_reg;
        drow_next = drow_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                row_next = q_req.row[9:0];
                col_next = '0;
            end
            ST_PTR0:   k_next = ptr_rd;
            ST_PTR1:   end_next = (ptr_rd > PtrW'(MaxNz)) ? PtrW'(MaxNz) : ptr_rd;
            ST_NZWAIT:
            begin
                drow_next = nzcol_rd;
                k_next    = k_reg + 1'b1;
                col_next  = '0;
            end
            ST_ACC:    col_next = (col_reg == ncm1) ? '0 : col_reg + 1'b1;
            ST_NZRD:   col_next = (k_reg < end_reg) ? col_reg : '0;
            ST_EMIT:
                if (!res_full_reg) col_next = (col_reg == ncm1) ? '0 : col_reg + 1'b1;
            default:   col_next = col_reg;
        endcase
    end

    // Truncate to Q16.16 and saturate.
    always_comb
    begin
        sat_sum = acc_reg[col_reg];
        q       = sat_sum[63:16];
        ovf     = (q[47:31] != {17{q[31]}});
        is_last = (col_reg == ncm1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            res_full_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_full_reg && res_ready)
                res_full_reg <= 1'b0;
            if (state_reg == ST_EMIT && !res_full_reg)
                res_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg  <= col_next;
        k_reg    <= k_next;
        end_reg  <= end_next;
        row_reg  <= row_next;
        drow_reg <= drow_next;
        if (state_reg == ST_NZWAIT)
            nzv_reg <= nzval_rd;
        if (state_reg == ST_MUL)
            prod_reg <= 64'(nzv_reg) * 64'($signed(dense_rd));
        // Accumulators clear at the start of every row.
        for (int i = 0; i < MaxCols; i++)
        begin
            if (state_reg == ST_IDLE)
                acc_reg[i] <= '0;
        end
        if (state_reg == ST_ACC)
        begin
            if (!prod_reg[63] && !acc_reg[col_reg][63] && (prod_reg + acc_reg[col_reg]) < 0)
                acc_reg[col_reg] <= 64'sh7FFF_FFFF_FFFF_FFFF;
            else if (prod_reg[63] && acc_reg[col_reg][63] && (prod_reg + acc_reg[col_reg]) >= 0)
                acc_reg[col_reg] <= 64'sh8000_0000_0000_0000;
            else
                acc_reg[col_reg] <= acc_reg[col_reg] + prod_reg;
        end
        if (state_reg == ST_EMIT && !res_full_reg)
        begin
            res.out_row    <= row_reg;
            res.out_column <= col_reg;
            res.sum        <= ovf ? (q[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : q[31:0];
            res.saturated  <= ovf;
            res.last       <= is_last;
        end
    end

    assign res_valid = res_full_reg;
    assign busy      = (state_reg != ST_IDLE) || res_full_reg;

endmodule
`default_nettype wire

@@ src/csr_sparse_dense_matmul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// CSR sparse by dense matrix multiply.
// Requests enter on the s_axis channel: mode 0 loads a dense element, mode 1 a
// row pointer, mode 2 a nonzero, mode 3 computes one result row. Results leave
// on m_axis, one per dense column in use, tlast on the final column.
// The user must write dense_columns over the APB port only while the block is
// idle; the block does not enforce this. A four-entry queue decouples
// acceptance from execution; loads retire as the idle back part pops them. The
// back part takes no new request until a compute request has registered its
// last result, a time set by the single shared multiplier and the registered
// read of the dense store. Memories have no reset; after reset the queue is
// empty and dense_columns is 1. When m_axis stalls, the result register holds,
// the back part waits, and once the queue fills s_axis_tready drops.
module csr_sparse_dense_matmul (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // mode[1:0], row[12:2], column[16:13], pointer[29:17], nonzero_slot[41:30],
    // nonzero_column[51:42], value[83:52], zero fill to 88 bits.
    input  wire logic [87:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_row[9:0], out_column[13:10], sum[45:14], saturated[46], zero fill.
    output logic [47:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import csd_pkg::*;
    `include "assert_macros.svh"

    req_t       in_req, q_req;
    res_t       res;
    logic       q_valid, q_pop, busy;
    logic [4:0] ncols_reg;

    assign in_req.mode      = mode_t'(s_axis_tdata[1:0]);
    assign in_req.row       = s_axis_tdata[12:2];
    assign in_req.column    = s_axis_tdata[16:13];
    assign in_req.pointer   = s_axis_tdata[29:17];
    assign in_req.slot      = s_axis_tdata[41:30];
    assign in_req.nz_column = s_axis_tdata[51:42];
    assign in_req.value     = s_axis_tdata[83:52];

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr[1:0] == {RegDenseColumns[1:0]}) ? {27'd0, ncols_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ncols_reg <= 5'd1;
        else if (psel && penable && pwrite && paddr == {RegDenseColumns[1:0]})
            ncols_reg <= pwdata[4:0];
    end

    csd_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_req(in_req), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req));

    csd_back u_back (
        .clk(clk), .rst_n(rst_n), .ncols_cfg(ncols_reg), .q_valid(q_valid),
        .q_pop(q_pop), .q_req(q_req), .res_valid(m_axis_tvalid),
        .res_ready(m_axis_tready), .res(res), .busy(busy));

    assign m_axis_tdata = {1'b0, res.saturated, res.sum, res.out_column, res.out_row};
    assign m_axis_tlast = res.last;

    // A result that waits is held until taken.
    `ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    // The queue is only drained while it has entries.
    `ASSERT_IMPLY(a_pop, clk, rst_n, q_pop, q_valid)
    // A result is only shown while the back part is busy.
    `ASSERT_IMPLY(a_busy, clk, rst_n, m_axis_tvalid, busy)

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import csd_pkg::*;

    localparam int WatchdogLimit = 40000;
    localparam int SettleCycles = 40;

    // One request as the block sees it.
    typedef struct {
        mode_t              mode;
        logic [10:0]        row;
        logic [3:0]         column;
        logic [12:0]        pointer;
        logic [11:0]        slot;
        logic [9:0]         nz_column;
        logic signed [31:0] value;
    } request_t;

    // One expected result element.
    typedef struct {
        logic [9:0]         out_row;
        logic [3:0]         out_column;
        logic signed [31:0] sum;
        logic               saturated;
        logic               last;
    } element_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    csr_sparse_dense_matmul dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow copies of the block's stores, with a written flag per entry.
    logic signed [31:0] dense_mem [MaxRows*MaxCols];
    logic [12:0]        ptr_mem [MaxRows+1];
    logic [9:0]         nzcol_mem [MaxNz];
    logic signed [31:0] nzval_mem [MaxNz];
    bit                 dense_set [MaxRows*MaxCols];
    bit                 ptr_set [MaxRows+1];
    bit                 nz_set [MaxNz];
    logic [4:0]         dense_columns_reg;

    element_t pending_elements[$];
    bit       failed;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       quiet_cycles;

    // Clock.
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int columns_in_use();
        if (dense_columns_reg == 0)
            return 1;
        if (dense_columns_reg > MaxCols)
            return MaxCols;
        return dense_columns_reg;
    endfunction

    function automatic logic signed [63:0] add_clip64(logic signed [63:0] a,
                                                      logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF)
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (s < -65'sh0_8000_0000_0000_0000)
            return 64'sh8000_0000_0000_0000;
        return s[63:0];
    endfunction

    // Update the shadow stores and queue the row results that a request causes.
    task automatic predict_request(request_t rq);
        logic signed [63:0] acc [MaxCols];
        logic signed [63:0] q;
        element_t           e;
        int                 ncols;
        int                 first;
        int                 stop;
        int                 drow;
        case (rq.mode)
            MODE_DENSE:
            begin
                if (rq.row < MaxRows)
                begin
                    dense_mem[rq.row*MaxCols + rq.column] = rq.value;
                    dense_set[rq.row*MaxCols + rq.column] = 1'b1;
                end
            end
            MODE_PTR:
            begin
                if (rq.row <= MaxRows)
                begin
                    ptr_mem[rq.row] = rq.pointer;
                    ptr_set[rq.row] = 1'b1;
                end
            end
            MODE_NZ:
            begin
                nzcol_mem[rq.slot] = rq.nz_column;
                nzval_mem[rq.slot] = rq.value;
                nz_set[rq.slot] = 1'b1;
            end
            default:
            begin
                if (rq.row < MaxRows)
                begin
                    ncols = columns_in_use();
                    for (int c = 0; c < MaxCols; c++)
                        acc[c] = 0;
                    first = ptr_mem[rq.row];
                    stop = ptr_mem[rq.row + 1];
                    if (stop > MaxNz)
                        stop = MaxNz;
                    for (int k = first; k < stop; k++)
                    begin
                        drow = nzcol_mem[k];
                        for (int c = 0; c < ncols; c++)
                            acc[c] = add_clip64(acc[c],
                                64'(nzval_mem[k]) * 64'(dense_mem[drow*MaxCols + c]));
                    end
                    for (int c = 0; c < ncols; c++)
                    begin
                        q = acc[c] >>> 16;
                        e.saturated = 1'b0;
                        if (q > 64'sh7FFF_FFFF)
                        begin
                            q = 64'sh7FFF_FFFF;
                            e.saturated = 1'b1;
                        end
                        if (q < -64'sh8000_0000)
                        begin
                            q = -64'sh8000_0000;
                            e.saturated = 1'b1;
                        end
                        e.out_row = rq.row[9:0];
                        e.out_column = 4'(c);
                        e.sum = q[31:0];
                        e.last = (c + 1 == ncols);
                        pending_elements.push_back(e);
                    end
                end
            end
        endcase
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed(32'($urandom_range(65536 * 4))) - 32'sh0002_0000;
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic request_t blank_request(mode_t m);
        request_t rq;
        rq.mode = m;
        rq.row = 11'($urandom);
        rq.column = 4'($urandom);
        rq.pointer = 13'($urandom);
        rq.slot = 12'($urandom);
        rq.nz_column = 10'($urandom);
        rq.value = $signed($urandom);
        return rq;
    endfunction

    // Find an entry that a compute of this row would read but that was never
    // written, and build the load that fills it.
    function automatic bit find_missing(logic [10:0] r, output request_t fill);
        int first;
        int stop;
        int drow;
        fill = blank_request(MODE_PTR);
        if (r >= MaxRows)
            return 1'b0;
        for (int i = 0; i < 2; i++)
            if (!ptr_set[r + i])
            begin
                fill.row = 11'(r + i);
                fill.pointer = 13'($urandom_range(24));
                return 1'b1;
            end
        first = ptr_mem[r];
        stop = ptr_mem[r + 1];
        if (stop > MaxNz)
            stop = MaxNz;
        for (int k = first; k < stop; k++)
        begin
            if (!nz_set[k])
            begin
                fill.mode = MODE_NZ;
                fill.slot = 12'(k);
                fill.nz_column = ($urandom_range(9) == 0) ? 10'($urandom)
                                                          : 10'($urandom_range(15));
                fill.value = pick_value();
                return 1'b1;
            end
            drow = nzcol_mem[k];
            for (int c = 0; c < columns_in_use(); c++)
                if (!dense_set[drow*MaxCols + c])
                begin
                    fill.mode = MODE_DENSE;
                    fill.row = 11'(drow);
                    fill.column = 4'(c);
                    fill.value = pick_value();
                    return 1'b1;
                end
        end
        return 1'b0;
    endfunction

    // Send one request; entered and left at a falling edge.
    task automatic send_request(request_t rq);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        predict_request(rq);
        s_axis_tdata = {4'b0, rq.value, rq.nz_column, rq.slot, rq.pointer,
                        rq.column, rq.row, rq.mode};
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Fill whatever the row needs, then ask for it.
    task automatic compute_row(int r);
        request_t rq;
        while (find_missing(11'(r), rq))
            send_request(rq);
        rq = blank_request(MODE_ROW);
        rq.row = 11'(r);
        send_request(rq);
    endtask

    task automatic load_dense(int r, int c, logic signed [31:0] v);
        request_t rq;
        rq = blank_request(MODE_DENSE);
        rq.row = 11'(r);
        rq.column = 4'(c);
        rq.value = v;
        send_request(rq);
    endtask

    task automatic load_pointer(int r, int p);
        request_t rq;
        rq = blank_request(MODE_PTR);
        rq.row = 11'(r);
        rq.pointer = 13'(p);
        send_request(rq);
    endtask

    task automatic load_nonzero(int s, int col, logic signed [31:0] v);
        request_t rq;
        rq = blank_request(MODE_NZ);
        rq.slot = 12'(s);
        rq.nz_column = 10'(col);
        rq.value = v;
        send_request(rq);
    endtask

    // Wait for all results, let queued loads drain, then write the register.
    task automatic set_dense_columns(logic [4:0] n);
        while (pending_elements.size() != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = RegDenseColumns;
        pwdata = 32'(n);
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        dense_columns_reg = n;
    endtask

    // Saturation, empty and reversed rows, pointer clamping, ignored loads and row requests.
    task automatic test_edge_cases();
        request_t rq;
        load_dense(0, 0, 32'sh8000_0000);
        load_dense(1, 0, 32'sh7FFF_FFFF);
        for (int s = 0; s < 5; s++)
            load_nonzero(s, 0, 32'sh8000_0000);
        for (int s = 5; s < 8; s++)
            load_nonzero(s, 1, 32'sh8000_0000);
        load_nonzero(8, 1, 32'sh0001_0000);
        load_pointer(0, 0);
        load_pointer(1, 5);
        load_pointer(2, 8);
        load_pointer(3, 9);
        load_pointer(4, 9);
        load_pointer(5, 2);
        compute_row(0);
        compute_row(1);
        compute_row(2);
        compute_row(3);
        compute_row(4);
        // Last row, with an end pointer far past the nonzero store.
        load_pointer(MaxRows - 1, 4093);
        load_pointer(MaxRows, 8191);
        compute_row(MaxRows - 1);
        // Out-of-range requests that the block must ignore.
        load_dense(1500, 3, 32'sh1234_5678);
        load_pointer(MaxRows + 1, 0);
        rq = blank_request(MODE_ROW);
        rq.row = 11'd2047;
        send_request(rq);
    endtask

    task automatic test_column_limits();
        set_dense_columns(5'd0);
        compute_row(2);
        set_dense_columns(5'd31);
        compute_row(0);
        compute_row(2);
        set_dense_columns(5'd16);
        compute_row(1);
    endtask

    task automatic test_random(int count, int idle, int stall, logic [4:0] ncols);
        request_t rq;
        int       p;
        set_dense_columns(ncols);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int n = 0; n < count; n++)
        begin
            p = $urandom_range(99);
            if (p < 5)
            begin
                // Noise beyond the row range.
                rq = blank_request(mode_t'($urandom_range(3)));
                if (rq.mode == MODE_NZ)
                    rq.mode = MODE_DENSE;
                rq.row = 11'($urandom_range(2047, 1025));
                send_request(rq);
            end
            else if (p < 30)
                load_dense(($urandom_range(9) == 0) ? $urandom_range(1023)
                                                    : $urandom_range(15),
                           $urandom_range(15), pick_value());
            else if (p < 45)
                load_pointer($urandom_range(16), $urandom_range(24));
            else if (p < 65)
                load_nonzero($urandom_range(31),
                             ($urandom_range(9) == 0) ? $urandom_range(1023)
                                                      : $urandom_range(15),
                             pick_value());
            else
                compute_row($urandom_range(15));
        end
    endtask

    // Receiver stalls.
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Result checker.
    always @(posedge clk)
    begin
        element_t got;
        element_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.out_row = m_axis_tdata[9:0];
            got.out_column = m_axis_tdata[13:10];
            got.sum = m_axis_tdata[45:14];
            got.saturated = m_axis_tdata[46];
            got.last = m_axis_tlast;
            if (pending_elements.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                failed = 1'b1;
            end
            else
            begin
                want = pending_elements.pop_front();
                if (got != want)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WatchdogLimit)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        failed = 1'b0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        dense_columns_reg = 5'd1;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b1;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        for (int i = 0; i < MaxRows*MaxCols; i++)
            dense_set[i] = 1'b0;
        for (int i = 0; i <= MaxRows; i++)
            ptr_set[i] = 1'b0;
        for (int i = 0; i < MaxNz; i++)
            nz_set[i] = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_edge_cases();
        test_column_limits();
        test_random(50, 0, 0, 5'd16);
        test_random(50, 85, 0, 5'(1 + $urandom_range(15)));
        test_random(50, 0, 85, 5'd1);
        test_random(50, 35, 35, 5'(1 + $urandom_range(15)));
        while (pending_elements.size() != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
        if (!failed && pending_elements.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
